FILE: src/ray_box_slab_clip_2d_assert.svh
// Assertion macros for the ray box slab clip block.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef RAY_BOX_SLAB_CLIP_2D_ASSERT_SVH
`define RAY_BOX_SLAB_CLIP_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define RBSC_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define RBSC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`define RBSC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) rst |=> (prop)) \
    else $error("assertion failed");
`else
`define RBSC_ASSERT_IMPL(label, cond, prop)
`define RBSC_ASSERT_NEXT(label, cond, prop)
`define RBSC_ASSERT_RST(label, prop)
`endif
`endif

FILE: src/rbsc_pkg.sv
// Shared types, constants and helper functions for the ray box slab clip block.
// No dependencies.
package rbsc_pkg;

  localparam int Q_W        = 32;
  localparam int REM_W      = 48;
  localparam int DIV_STAGES = Q_W;
  localparam int LANES      = 4;

  localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_T_LOW    = 3'd4,
    REG_T_HIGH   = 3'd5
  } reg_index_t;

  // one restoring divider lane: remainder, quotient so far, divisor magnitude, sign and overflow flags
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic [31:0]      dv;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    logic pin;   // a window end point lies inside the box
    logic zx;    // dir_x is zero
    logic zy;
    logic cx;    // origin_x between x bounds
    logic cy;
  } slab_ctl_t;

  typedef struct packed {
    logic                        valid;
    slab_ctl_t                   ctl;
    div_lane_t [LANES-1:0]       lane;
  } div_stage_t;

  // one quotient bit at weight k
  function automatic div_lane_t div_step(div_lane_t l, logic [4:0] k);
    logic [REM_W-1:0] hi;
    logic [REM_W-1:0] sub;
    div_lane_t        r;
    r   = l;
    hi  = l.rem >> k;
    sub = {16'b0, l.dv} << k;
    if (hi >= {16'b0, l.dv}) begin
      r.rem    = l.rem - sub;
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  // sign the quotient magnitude and saturate to 32-bit Q16.16
  function automatic logic [31:0] sat_quo(div_lane_t l);
    logic [31:0] res;
    if (l.ovf) begin
      res = l.neg ? T_MIN : T_MAX;
    end else if (l.neg) begin
      res = (l.quo > T_MIN) ? T_MIN : (~l.quo + 32'd1);
    end else begin
      res = l.quo[31] ? T_MAX : l.quo;
    end
    return res;
  endfunction

endpackage

FILE: src/ray_box_slab_clip_2d.sv
// Top level of the 2D ray versus axis-aligned box slab test.
// Depends on rbsc_pkg and ray_box_slab_clip_2d_assert.svh.
// Usage:
//   cfg_*   : register writes (index, 32-bit data), always ready. Index 0..5 =
//             origin_x, origin_y, dir_x, dir_y, t_window_low, t_window_high;
//             other indexes are dropped. Write only while no box is in flight.
//   s_axis  : one box per word, s_tdata = {box_high_y, box_high_x,
//             box_low_y, box_low_x} from the top down.
//   m_axis  : one result per box, m_tuser = hit, m_tdata = {t_exit, t_enter};
//             both t fields are zero on a miss.
// Throughput: one box per cycle while the output word is not held. Pipeline:
// input and setup stages, the 32-stage restoring divider (one quotient bit per
// stage, four divider lanes side by side), then saturate, intersect and
// output stages.
// The whole pipeline advances together: when the output word is held by
// the receiver, every stage holds and s_tready drops; nothing is lost or
// repeated. s_tready is high whenever the output register is empty or taken.
// Reset: synchronous, clears all valid bits and restores the reset ray
// (origin (0, 0), direction (65536, 0), window [0, 1.0]).
module ray_box_slab_clip_2d
  import rbsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // box_low_x, box_low_y, box_high_x, box_high_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // t_enter, t_exit
  output logic [0:0]   m_tuser    // hit
);

`include "ray_box_slab_clip_2d_assert.svh"

  // configuration registers
  logic [31:0] origin_x, origin_y, dir_x, dir_y, t_window_low, t_window_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      dir_x         <= 32'h0001_0000;
      dir_y         <= '0;
      t_window_low  <= '0;
      t_window_high <= 32'h0001_0000;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_X: origin_x      <= cfg_data;
        REG_ORIGIN_Y: origin_y      <= cfg_data;
        REG_DIR_X:    dir_x         <= cfg_data;
        REG_DIR_Y:    dir_y         <= cfg_data;
        REG_T_LOW:    t_window_low  <= cfg_data;
        REG_T_HIGH:   t_window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // window-end offsets t_w * dir, refreshed every cycle from the registers;
  // valid if the user holds config static while boxes are in flight (unchecked)
  logic signed [63:0] prod_lo_x, prod_lo_y, prod_hi_x, prod_hi_y;

  always_ff @(posedge clk) begin
    prod_lo_x <= $signed(t_window_low)  * $signed(dir_x);
    prod_lo_y <= $signed(t_window_low)  * $signed(dir_y);
    prod_hi_x <= $signed(t_window_high) * $signed(dir_x);
    prod_hi_y <= $signed(t_window_high) * $signed(dir_y);
  end

  // global advance: hold everything while the output word waits
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: capture box
  logic        s1_valid;
  logic [31:0] s1_lx, s1_ly, s1_hx, s1_hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
      s1_lx    <= s_tdata[31:0];
      s1_ly    <= s_tdata[63:32];
      s1_hx    <= s_tdata[95:64];
      s1_hy    <= s_tdata[127:96];
    end
  end

  // stage 2: offsets from origin, divider setup, window point containment
  logic signed [32:0] d_lx, d_hx, d_ly, d_hy;
  logic [31:0]        m_lx, m_hx, m_ly, m_hy;
  logic [31:0]        dv_x, dv_y;
  logic               in_lo, in_hi, cont_x, cont_y;
  div_stage_t         pipe [DIV_STAGES+1];

  function automatic logic [31:0] mag33(logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? (~v + 33'd1) : v;
    return a[31:0];
  endfunction

  function automatic logic signed [63:0] scale(logic signed [32:0] v);
    return {{15{v[32]}}, v, 16'b0};
  endfunction

  function automatic div_lane_t lane_init(logic [31:0] m, logic sgn,
                                          logic [31:0] dv, logic dneg);
    div_lane_t l;
    l.rem = {m, 16'b0};
    l.quo = '0;
    l.dv  = dv;
    l.neg = sgn ^ dneg;
    l.ovf = ({16'b0, m[31:16]} >= dv);
    return l;
  endfunction

  always_comb begin
    d_lx = $signed({s1_lx[31], s1_lx}) - $signed({origin_x[31], origin_x});
    d_hx = $signed({s1_hx[31], s1_hx}) - $signed({origin_x[31], origin_x});
    d_ly = $signed({s1_ly[31], s1_ly}) - $signed({origin_y[31], origin_y});
    d_hy = $signed({s1_hy[31], s1_hy}) - $signed({origin_y[31], origin_y});
    m_lx = mag33(d_lx);
    m_hx = mag33(d_hx);
    m_ly = mag33(d_ly);
    m_hy = mag33(d_hy);
    dv_x = mag33($signed({dir_x[31], dir_x}));
    dv_y = mag33($signed({dir_y[31], dir_y}));
    // origin between bounds in either order
    cont_x = ((d_lx <= 0) && (d_hx >= 0)) || ((d_hx <= 0) && (d_lx >= 0));
    cont_y = ((d_ly <= 0) && (d_hy >= 0)) || ((d_hy <= 0) && (d_ly >= 0));
    // exact inclusive test: t_w*dir against (bound - origin) << 16
    in_lo = (prod_lo_x >= scale(d_lx)) && (prod_lo_x <= scale(d_hx)) &&
            (prod_lo_y >= scale(d_ly)) && (prod_lo_y <= scale(d_hy));
    in_hi = (prod_hi_x >= scale(d_lx)) && (prod_hi_x <= scale(d_hx)) &&
            (prod_hi_y >= scale(d_ly)) && (prod_hi_y <= scale(d_hy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0].valid   <= s1_valid;
      pipe[0].ctl.pin <= in_lo || in_hi;
      pipe[0].ctl.zx  <= (dir_x == '0);
      pipe[0].ctl.zy  <= (dir_y == '0);
      pipe[0].ctl.cx  <= cont_x;
      pipe[0].ctl.cy  <= cont_y;
      pipe[0].lane[0] <= lane_init(m_lx, d_lx[32], dv_x, dir_x[31]);
      pipe[0].lane[1] <= lane_init(m_hx, d_hx[32], dv_x, dir_x[31]);
      pipe[0].lane[2] <= lane_init(m_ly, d_ly[32], dv_y, dir_y[31]);
      pipe[0].lane[3] <= lane_init(m_hy, d_hy[32], dv_y, dir_y[31]);
    end
  end

  // divider stages: stage j resolves quotient bit Q_W-1-j on all four lanes
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[j+1].valid <= 1'b0;
      end else if (en) begin
        pipe[j+1].valid <= pipe[j].valid;
        pipe[j+1].ctl   <= pipe[j].ctl;
        for (int i = 0; i < LANES; i++) begin
          pipe[j+1].lane[i] <= div_step(pipe[j].lane[i], 5'(Q_W - 1 - j));
        end
      end
    end
  end

  // stage 3: saturate and order slab parameters per axis
  logic        s3_valid, s3_ok, s3_pin;
  logic [31:0] s3_t0x, s3_t1x, s3_t0y, s3_t1y;
  logic [31:0] qa_x, qb_x, qa_y, qb_y;
  div_stage_t  dq;

  always_comb begin
    dq   = pipe[DIV_STAGES];
    qa_x = sat_quo(dq.lane[0]);
    qb_x = sat_quo(dq.lane[1]);
    qa_y = sat_quo(dq.lane[2]);
    qb_y = sat_quo(dq.lane[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= dq.valid;
      s3_pin   <= dq.ctl.pin;
      s3_ok    <= (!dq.ctl.zx || dq.ctl.cx) && (!dq.ctl.zy || dq.ctl.cy);
      if (dq.ctl.zx) begin
        s3_t0x <= T_MIN;
        s3_t1x <= T_MAX;
      end else if ($signed(qa_x) > $signed(qb_x)) begin
        s3_t0x <= qb_x;
        s3_t1x <= qa_x;
      end else begin
        s3_t0x <= qa_x;
        s3_t1x <= qb_x;
      end
      if (dq.ctl.zy) begin
        s3_t0y <= T_MIN;
        s3_t1y <= T_MAX;
      end else if ($signed(qa_y) > $signed(qb_y)) begin
        s3_t0y <= qb_y;
        s3_t1y <= qa_y;
      end else begin
        s3_t0y <= qa_y;
        s3_t1y <= qb_y;
      end
    end
  end

  // stage 4: intersect the two slab ranges
  logic        s4_valid, s4_ok, s4_pin;
  logic [31:0] s4_tmin, s4_tmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
      s4_pin   <= s3_pin;
      s4_ok    <= s3_ok && !($signed(s3_t0x) > $signed(s3_t1y)) &&
                  !($signed(s3_t0y) > $signed(s3_t1x));
      s4_tmin  <= ($signed(s3_t0y) > $signed(s3_t0x)) ? s3_t0y : s3_t0x;
      s4_tmax  <= ($signed(s3_t1y) < $signed(s3_t1x)) ? s3_t1y : s3_t1x;
    end
  end

  // stage 5: clip to the window when an end point is inside, then window test
  logic [31:0] c_tmin, c_tmax;
  logic        c_hit;

  always_comb begin
    c_tmin = s4_tmin;
    c_tmax = s4_tmax;
    if (s4_pin) begin
      if ($signed(t_window_high) < $signed(s4_tmax)) c_tmax = t_window_high;
      if ($signed(t_window_low) > $signed(s4_tmin))  c_tmin = t_window_low;
    end
    c_hit = s4_ok && !($signed(c_tmin) < $signed(t_window_low)) &&
            !($signed(c_tmax) > $signed(t_window_high));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid   <= s4_valid;
      m_tuser[0] <= c_hit;
      m_tdata    <= c_hit ? {c_tmax, c_tmin} : 64'd0;
    end
  end

  `RBSC_ASSERT_IMPL(a_miss_zero_t, m_tvalid && !m_tuser[0], m_tdata == 64'd0)
  `RBSC_ASSERT_NEXT(a_hold_stage4, s4_valid && !en, s4_valid && m_tvalid)
  `RBSC_ASSERT_IMPL(a_accept_when_free, !m_tvalid, s_tready)
  `RBSC_ASSERT_RST(a_reset_empty, !m_tvalid && !s1_valid && !s4_valid)

endmodule
